>>> design/chg_pkg.sv
// ----------------------------------------------------------------------------
// chg_pkg
// Types and constants shared by the canonical Huffman code generator.
// ----------------------------------------------------------------------------
`default_nettype none

package chg_pkg;

  localparam int unsigned CountBytes = 16;          // length counts per table
  localparam int unsigned SymbolPos  = 17;          // byte position of symbols
  localparam int unsigned PosW       = 5;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned LenW       = 5;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned NextCodeW  = 17;
  localparam int unsigned QDepth     = 2;

  typedef enum logic [1:0] {
    OP_RESTART,
    OP_COUNT,
    OP_SYMBOL
  } chg_op_e;

  typedef struct packed {
    chg_op_e         op;
    logic [IdxW-1:0] idx;
    logic [7:0]      data;
  } chg_op_t;

endpackage

`default_nettype wire

>>> design/chg_if.sv
// ----------------------------------------------------------------------------
// chg_if
// Valid/ready channels of the code generator: table bytes in, codes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface chg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, data_byte, first, input ready);
  modport sink   (input valid, data_byte, first, output ready);
endinterface

interface chg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code;
  logic [4:0]  code_length;
  logic [7:0]  symbol;
  logic        error;

  modport source (output valid, code, code_length, symbol, error, input ready);
  modport sink   (input valid, code, code_length, symbol, error, output ready);
endinterface

`default_nettype wire

>>> design/chg_front.sv
// ----------------------------------------------------------------------------
// chg_front
// Tracks the byte position in the table and turns each byte after a header into an op.
// ----------------------------------------------------------------------------
`default_nettype none

module chg_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            first_i,
  output logic                 push_o,
  output chg_pkg::chg_op_t     op_o,
  input  wire logic            full_i
);
  import chg_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            take;

  assign ready_o = !full_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    pos_d   = pos_q;
    push_o  = 1'b0;
    op_o.op   = OP_SYMBOL;
    op_o.idx  = IdxW'(pos_q - PosW'(1));
    op_o.data = data_byte_i;
    if (take) begin
      if (first_i) begin
        pos_d   = PosW'(1);
        push_o  = 1'b1;
        op_o.op = OP_RESTART;
      end else if (pos_q == '0) begin
        // drop bytes ahead of any header
        push_o = 1'b0;
      end else if (pos_q < PosW'(SymbolPos)) begin
        pos_d   = pos_q + PosW'(1);
        push_o  = 1'b1;
        op_o.op = OP_COUNT;
      end else begin
        push_o  = 1'b1;
        op_o.op = OP_SYMBOL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  pos_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(SymbolPos))
    else $error("byte position out of range");

  restart_pos_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && first_i |=> pos_q == PosW'(1))
    else $error("header byte did not restart the table");

  header_push_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && first_i |-> push_o && op_o.op == OP_RESTART)
    else $error("header byte lost");

endmodule

`default_nettype wire

>>> design/chg_queue.sv
// ----------------------------------------------------------------------------
// chg_queue
// Short FIFO of classified ops between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module chg_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire chg_pkg::chg_op_t op_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output chg_pkg::chg_op_t      op_o
);
  import chg_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  chg_op_t         mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            pop, push;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign push    = push_i && !full_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("queue count overflow");

  no_lost_push_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  pop_empty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push && cnt_q == CntW'(1) |=> !valid_o)
    else $error("queue count out of step");

endmodule

`default_nettype wire

>>> design/chg_back.sv
// ----------------------------------------------------------------------------
// chg_back
// Holds the length counts and code state, assigns canonical codes to symbols
// and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module chg_back #(
  parameter int unsigned MAX_CODE_LENGTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire chg_pkg::chg_op_t op_i,
  chg_out_if.source             out_o
);
  import chg_pkg::*;

  logic [7:0]           counts_q [CountBytes];
  logic [LenW-1:0]      cur_q, cur_d;
  logic [7:0]           left_q, left_d;
  logic [NextCodeW-1:0] nc_q, nc_d;

  logic                 out_valid_q;
  logic [CodeW-1:0]     out_code_q;
  logic [LenW-1:0]      out_len_q;
  logic [7:0]           out_sym_q;
  logic                 out_err_q;

  logic                 can_load, pop, sym_take;
  logic                 found;
  logic [LenW-1:0]      flen, len_n;
  logic [7:0]           left_n;
  logic [NextCodeW-1:0] code_n;
  logic                 err;

  assign can_load = !out_valid_q || out_o.ready;
  assign ready_o  = (op_i.op != OP_SYMBOL) || can_load;
  assign pop      = valid_i && ready_o;
  assign sym_take = pop && (op_i.op == OP_SYMBOL);

  // find the shortest longer length that still has codes
  always_comb begin
    found = 1'b0;
    flen  = LenW'(MAX_CODE_LENGTH);
    for (int i = CountBytes - 1; i >= 0; i--) begin
      if (counts_q[i] != '0 && LenW'(i + 1) > cur_q && (i + 1) <= MAX_CODE_LENGTH) begin
        found = 1'b1;
        flen  = LenW'(i + 1);
      end
    end
  end

  always_comb begin
    if (left_q != '0) begin
      len_n  = cur_q;
      left_n = left_q;
      code_n = nc_q;
    end else begin
      len_n  = flen;
      left_n = found ? counts_q[IdxW'(flen - LenW'(1))] : '0;
      code_n = nc_q << (flen - cur_q);
    end
    err = (left_n == '0) || ((code_n >> len_n) != '0);
  end

  always_comb begin
    cur_d  = cur_q;
    left_d = left_q;
    nc_d   = nc_q;
    if (pop) begin
      case (op_i.op)
        OP_RESTART: begin
          cur_d  = '0;
          left_d = '0;
          nc_d   = '0;
        end
        OP_SYMBOL: begin
          cur_d = len_n;
          if (err) begin
            left_d = left_n;
            nc_d   = code_n;
          end else begin
            left_d = left_n - 8'd1;
            nc_d   = code_n + NextCodeW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && op_i.op == OP_COUNT) begin
      counts_q[op_i.idx] <= op_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      left_q      <= '0;
      nc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      left_q <= left_d;
      nc_q   <= nc_d;
      if (sym_take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sym_take) begin
      out_code_q <= err ? '0 : code_n[CodeW-1:0];
      out_len_q  <= err ? '0 : len_n;
      out_sym_q  <= op_i.data;
      out_err_q  <= err;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.code        = out_code_q;
  assign out_o.code_length = out_len_q;
  assign out_o.symbol      = out_sym_q;
  assign out_o.error       = out_err_q;

  cur_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= LenW'(MAX_CODE_LENGTH))
    else $error("current length beyond maximum");

  code_fits_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_err_q |->
      out_len_q != '0 && ({1'b0, out_code_q} >> out_len_q) == '0)
    else $error("code does not fit its length");

  err_clear_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_len_q == '0 && out_code_q == '0)
    else $error("error result carries a code");

  sym_out_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_take |=> out_valid_q)
    else $error("symbol result lost");

endmodule

`default_nettype wire

>>> design/canonical_huffman_code_generator_unit.sv
// ----------------------------------------------------------------------------
// canonical_huffman_code_generator_unit
// Canonical Huffman code generator for JPEG table segments.
//
// in_i carries table bytes; first marks the class/id byte that restarts the
// table. The next 16 bytes are code counts for lengths 1..16, every later
// byte is a symbol. out_o returns one item per symbol: its canonical code,
// code length and the symbol, or error with zero code and length when the
// counts overfill the code space or the symbol is beyond the counted total.
// Header and count bytes give no output item; bytes before any header drop.
//
// One byte is taken per cycle while the op queue has room. A symbol's op is
// registered in the op queue; at the head of the queue the code assignment
// stage works on it, and its result lands in the output register.
// Skipping empty lengths is a priority encode over the stored counts inside
// that stage, so the rate stays one item per cycle while out_o is not
// stalled. When out_o stalls, the output register holds its item, the
// two-entry op queue fills and in_i.ready drops.
// Reset empties the queue and the output register and returns to waiting
// for a header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_code_generator_unit #(
  parameter int unsigned MAX_CODE_LENGTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  chg_in_if.sink    in_i,
  chg_out_if.source out_o
);
  import chg_pkg::*;

  logic    push, full, q_valid, q_ready;
  chg_op_t push_op, q_op;

  chg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .data_byte_i (in_i.data_byte),
    .first_i     (in_i.first),
    .push_o      (push),
    .op_o        (push_op),
    .full_i      (full)
  );

  chg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .op_o    (q_op)
  );

  chg_back #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .op_i    (q_op),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

>>> bench/canonical_huffman_code_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_code_generator_unit_tb
// Feeds JPEG Huffman table segments byte by byte and checks every code item
// against a canonical code predictor kept in step with the accepted bytes.
// The first rows come from a fixed table with hand-derived codes. Random
// tables follow: well-formed tables, fully packed tables, overfilled tables,
// noise counts and tables cut short by a new header. Both channels stall at
// random in the first two phases; in the third the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------

module canonical_huffman_code_generator_unit_tb;
  import chg_pkg::*;

  localparam int MaxLen     = 16;
  localparam int DirRows    = 25;
  localparam int RandItems  = 450;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  code_length;
    logic [7:0]       symbol;
    logic             error;
  } code_item_t;

  // One table byte plus, for fixed rows, the item it must produce.
  typedef struct packed {
    logic [7:0]       data;
    logic             first;
    logic             typed;
    logic             has_res;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
    logic             err;
  } table_byte_t;

  // Stray byte, header, counts with three codes at length 1 and 255 at
  // length 16, four symbols (last two overfill), then a header cut short.
  localparam table_byte_t DirTable [DirRows] = '{
    '{8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h03, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 5'd1, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 16'h0001, 5'd1, 1'b0},
    '{8'h5A, 1'b0, 1'b1, 1'b1, 16'h0000, 5'd0, 1'b1},
    '{8'h81, 1'b0, 1'b1, 1'b1, 16'h0000, 5'd0, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 1'b0, 16'h0000, 5'd0, 1'b0}
  };

  logic clk;
  logic rst_n;

  chg_in_if  in_if ();
  chg_out_if out_if ();

  canonical_huffman_code_generator_unit #(
    .MAX_CODE_LENGTH(MaxLen)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predictor state
  logic [7:0]           len_counts [CountBytes];
  logic [PosW-1:0]      tbl_pos;
  logic [LenW-1:0]      cur_len;
  logic [7:0]           codes_left;
  logic [NextCodeW-1:0] code_next;

  code_item_t  pending_codes [$];
  table_byte_t table_bytes [$];
  int          phase;
  int          fails;
  int          cycles;
  bit          bytes_done;

  function automatic bit next_canonical_code(input logic [7:0] b, input logic hdr,
                                             output code_item_t res);
    res = '0;
    if (hdr) begin
      tbl_pos    = 5'd1;
      cur_len    = '0;
      codes_left = '0;
      code_next  = '0;
      return 1'b0;
    end
    if (tbl_pos == '0) return 1'b0;
    if (tbl_pos <= CountBytes) begin
      len_counts[IdxW'(tbl_pos - 5'd1)] = b;
      tbl_pos = tbl_pos + 5'd1;
      return 1'b0;
    end
    // advance past lengths with no codes left
    while (codes_left == '0 && cur_len < MaxLen) begin
      cur_len    = cur_len + 5'd1;
      code_next  = {code_next[NextCodeW-2:0], 1'b0};
      codes_left = len_counts[IdxW'(cur_len - 5'd1)];
    end
    res.symbol = b;
    if (codes_left == '0 || 32'(code_next) >= (32'd1 << cur_len)) begin
      res.error = 1'b1;
      return 1'b1;
    end
    res.code        = code_next[CodeW-1:0];
    res.code_length = cur_len;
    code_next  = code_next + NextCodeW'(1);
    codes_left = codes_left - 8'd1;
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: build the byte stream, then offer it with random gaps.
  initial begin : drive_bytes
    int          cnt [CountBytes];
    int          mode, nsym, ncount, left_total, code_pt, avail, hi, k, idle;
    table_byte_t tb;
    code_item_t  got;
    bit          has;

    phase      = 0;
    bytes_done = 1'b0;
    tbl_pos    = '0;
    cur_len    = '0;
    codes_left = '0;
    code_next  = '0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.first     <= 1'b0;

    foreach (DirTable[r]) table_bytes.insert(table_bytes.size(), DirTable[r]);

    while (table_bytes.size() < DirRows + RandItems) begin
      mode   = $urandom_range(0, 99);
      nsym   = 0;
      ncount = CountBytes;
      foreach (cnt[l]) cnt[l] = 0;
      if (mode < 50) begin
        // well-formed: never exceed the free code space at any length
        left_total = $urandom_range(1, 24);
        code_pt    = 0;
        for (int l = 0; l < CountBytes; l++) begin
          code_pt = code_pt * 2;
          avail   = (1 << (l + 1)) - code_pt;
          hi      = (avail < left_total) ? avail : left_total;
          if (hi > 6) hi = 6;
          if ($urandom_range(0, 2) == 0) cnt[l] = $urandom_range(0, hi);
          code_pt    += cnt[l];
          left_total -= cnt[l];
          nsym       += cnt[l];
        end
        nsym += $urandom_range(0, 1);
      end else if (mode < 65) begin
        // packed full: last code is all ones at length k
        k = $urandom_range(1, 16);
        for (int l = 0; l < k - 1; l++) cnt[l] = 1;
        cnt[k-1] = 2;
        nsym = k + 1 + $urandom_range(0, 1);
      end else if (mode < 80) begin
        k = $urandom_range(0, 3);
        foreach (cnt[l]) cnt[l] = $urandom_range(0, 1);
        cnt[k] = (2 << k) + $urandom_range(0, 3);
        nsym = $urandom_range(4, 14);
      end else if (mode < 90) begin
        foreach (cnt[l]) cnt[l] = $urandom_range(0, 255);
        nsym = $urandom_range(1, 10);
      end else begin
        // cut short: the next header restarts mid-count
        foreach (cnt[l]) cnt[l] = $urandom_range(0, 255);
        ncount = $urandom_range(0, 15);
      end
      tb = '{8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, 16'h0, 5'd0, 1'b0};
      table_bytes.insert(table_bytes.size(), tb);
      for (int l = 0; l < ncount; l++) begin
        tb = '{8'(cnt[l]), 1'b0, 1'b0, 1'b0, 16'h0, 5'd0, 1'b0};
        table_bytes.insert(table_bytes.size(), tb);
      end
      for (int s = 0; s < nsym; s++) begin
        tb = '{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 16'h0, 5'd0, 1'b0};
        table_bytes.insert(table_bytes.size(), tb);
      end
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    for (int i = 0; i < table_bytes.size(); i++) begin
      if (i == table_bytes.size() / 3) begin
        // hold off until every pending code has come out
        in_if.valid <= 1'b0;
        do @(posedge clk); while (pending_codes.size() != 0);
        phase = 1;
      end
      if (i == 2 * table_bytes.size() / 3) phase = 2;
      idle = (phase == 0) ? 13 : (phase == 1) ? 70 : 0;
      while ($urandom_range(0, 99) < idle) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
      tb = table_bytes[i];
      in_if.valid     <= 1'b1;
      in_if.data_byte <= tb.data;
      in_if.first     <= tb.first;
      do @(posedge clk); while (!in_if.ready);
      has = next_canonical_code(tb.data, tb.first, got);
      if (tb.typed) begin
        has = tb.has_res;
        got = '{tb.code, tb.len, tb.data, tb.err};
      end
      if (has) pending_codes.insert(pending_codes.size(), got);
    end
    in_if.valid <= 1'b0;
    bytes_done = 1'b1;
  end

  // Receiver: stall at random, once for a long stretch, and check each item.
  initial begin : take_codes
    code_item_t want;
    bit         held;
    int         hold_left;
    int         idle;

    held      = 1'b0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        if (pending_codes.size() == 0) begin
          $error("unexpected code item for symbol %0h", out_if.symbol);
          fails++;
        end else begin
          want = pending_codes.pop_front();
          if (out_if.code !== want.code) begin
            $error("code: expected %0h, got %0h", want.code, out_if.code);
            fails++;
          end
          if (out_if.code_length !== want.code_length) begin
            $error("code_length: expected %0d, got %0d", want.code_length,
                   out_if.code_length);
            fails++;
          end
          if (out_if.symbol !== want.symbol) begin
            $error("symbol: expected %0h, got %0h", want.symbol, out_if.symbol);
            fails++;
          end
          if (out_if.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, out_if.error);
            fails++;
          end
        end
      end
      if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      idle = (phase == 0) ? 70 : (phase == 1) ? 13 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= idle);
      end
    end
  end

  initial begin : finish_run
    wait (bytes_done);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
